[rtl/sha1_pkg.sv]
// shared types, constants and helpers of the sha-1 hash engine
// used by sha1_ctrl, sha1_dp and sha1_hash_engine_top; no dependencies
package sha1_pkg;

    localparam int WORD_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int BLOCK_W  = 512;
    localparam int NWORDS   = 5;
    localparam int ROUNDS   = 80;
    localparam int ROUND_W  = 7;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 64;
    localparam int IDX_W    = 3;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
    localparam logic [POS_W-1:0]   POS_FULL   = '1;
    localparam logic [POS_W-1:0]   POS_LEN    = 6'd56;
    localparam logic [IDX_W-1:0]   LAST_WORD  = IDX_W'(NWORDS - 1);
    localparam logic [IDX_W-1:0]   LAST_LEN   = '1;

    localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;
    localparam logic [LEN_W-1:0]   BITS_PER_BYTE = 64'd8;

    localparam logic [WORD_W-1:0] IV [NWORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

    // controller states, one-hot
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PAD80  = 7'b0000010,
        ST_ZERO   = 7'b0000100,
        ST_LEN    = 7'b0001000,
        ST_ROUND  = 7'b0010000,
        ST_ADD    = 7'b0100000,
        ST_DIGEST = 7'b1000000
    } state_t;

    // source of the byte shifted into the block
    typedef enum logic [1:0] {
        SEL_MSG  = 2'd0,
        SEL_PAD  = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic               put;
        byte_sel_t          byte_sel;
        logic [IDX_W-1:0]   len_idx;
        logic               add_len;
        logic               load_rounds;
        logic               round;
        logic [ROUND_W-1:0] round_idx;
        logic               add_h;
        logic               emit;
    } cmd_t;

    typedef struct packed {
        logic pos_full;
        logic pos_at_len;
        logic out_busy;
    } status_t;

    // round constant for each group of twenty rounds
    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] r);
        logic [WORD_W-1:0] k;
        if (r < 7'd20) begin
            k = K0;
        end else if (r < 7'd40) begin
            k = K1;
        end else if (r < 7'd60) begin
            k = K2;
        end else begin
            k = K3;
        end
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

[rtl/sha1_hash_engine_top.sv]
// top level of the streaming sha-1 hash engine
// instantiates sha1_ctrl and sha1_dp; depends on sha1_pkg
//
// channel  dir  tdata                               tuser      tlast
// s_       in   [7:0] data_byte                     has_byte   last
// m_       out  [31:0] digest_word, [34:32] index   -          last_word
//
// a byte that does not close a block is taken on its own; a byte that closes a block
// also starts a compression (intake, 80 rounds of the single round unit, add)
// finishing emits pad bytes one per cycle, pausing while a compression runs and before
// the length bytes, and runs one or two compressions before the digest is loaded
// the digest then leaves as five transfers from the output stage while the
// next message is already taken; a second digest waits until it drains
// aresetn is synchronous, active low, and restores the initial vector
module sha1_hash_engine_top
    import sha1_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,   // message end
    // digest words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);

    cmd_t              cmd;
    status_t           status;
    logic [WORD_W-1:0] out_word;
    logic [IDX_W-1:0]  out_idx;

    // controller sees only valid items; acceptance is tvalid with tready
    sha1_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_has_byte (s_tuser),
        .in_last     (s_tlast),
        .in_ready    (s_tready),
        .status      (status),
        .cmd         (cmd)
    );

    sha1_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word),
        .out_idx   (out_idx),
        .out_last  (m_tlast)
    );

    // pack the result fields, zero fill to whole bytes
    assign m_tdata = {5'b00000, out_idx, out_word};

endmodule

[rtl/sha1_ctrl.sv]
// sequencer of the sha-1 engine: byte intake, padding, rounds, digest hand-off
// depends on sha1_pkg
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    in_has_byte,
    input  logic    in_last,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t             state_reg, state_next;
    state_t             resume_reg, resume_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [IDX_W-1:0]   len_idx_reg, len_idx_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        resume_next  = resume_reg;
        round_next   = round_reg;
        len_idx_next = len_idx_reg;
        cmd          = '0;
        cmd.byte_sel = SEL_MSG;
        cmd.len_idx  = len_idx_reg;
        cmd.round_idx = round_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_has_byte) begin
                        cmd.put     = 1'b1;
                        cmd.add_len = 1'b1;
                        if (status.pos_full) begin
                            cmd.load_rounds = 1'b1;
                            state_next  = ST_ROUND;
                            resume_next = in_last ? ST_PAD80 : ST_IDLE;
                        end else if (in_last) begin
                            state_next = ST_PAD80;
                        end
                    end else if (in_last) begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                cmd.put      = 1'b1;
                cmd.byte_sel = SEL_PAD;
                if (status.pos_full) begin
                    cmd.load_rounds = 1'b1;
                    state_next  = ST_ROUND;
                    resume_next = ST_ZERO;
                end else begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (status.pos_at_len) begin
                    state_next   = ST_LEN;
                    len_idx_next = '0;
                end else begin
                    cmd.put      = 1'b1;
                    cmd.byte_sel = SEL_ZERO;
                    if (status.pos_full) begin
                        cmd.load_rounds = 1'b1;
                        state_next  = ST_ROUND;
                        resume_next = ST_ZERO;
                    end
                end
            end
            ST_LEN: begin
                cmd.put      = 1'b1;
                cmd.byte_sel = SEL_LEN;
                if (len_idx_reg == LAST_LEN) begin
                    cmd.load_rounds = 1'b1;
                    state_next  = ST_ROUND;
                    resume_next = ST_DIGEST;
                end else begin
                    len_idx_next = len_idx_reg + 1'b1;
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (round_reg == LAST_ROUND) begin
                    round_next = '0;
                    state_next = ST_ADD;
                end else begin
                    round_next = round_reg + 1'b1;
                end
            end
            ST_ADD: begin
                cmd.add_h  = 1'b1;
                state_next = resume_reg;
            end
            ST_DIGEST: begin
                if (!status.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            resume_reg  <= ST_IDLE;
            round_reg   <= '0;
            len_idx_reg <= '0;
        end else begin
            state_reg   <= state_next;
            resume_reg  <= resume_next;
            round_reg   <= round_next;
            len_idx_reg <= len_idx_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a compression always returns to the point that started it
    a_add_resumes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD) |=> (state_reg == $past(resume_reg)))
        else $error("add step did not resume the saved state");

    // the last length byte always closes a block
    a_len_closes_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEN && len_idx_reg == LAST_LEN) |-> status.pos_full)
        else $error("length bytes not aligned to block end");

    // rounds only start right after a block load
    a_round_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_ROUND) |-> ($past(cmd.load_rounds) && round_reg == '0))
        else $error("rounds started without a block load");
`endif

endmodule

[rtl/sha1_dp.sv]
// sha-1 datapath: block shift register, round unit, chaining words, length
// counter and the digest output stage; depends on sha1_pkg
module sha1_dp
    import sha1_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_word,
    output logic [IDX_W-1:0]  out_idx,
    output logic              out_last
);

    logic [BLOCK_W-1:0]        blk_reg;
    logic [WORD_W-1:0]         a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WORD_W-1:0]         h_reg [NWORDS];
    logic [POS_W-1:0]          pos_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [NWORDS*WORD_W-1:0]  out_data_reg;
    logic [IDX_W-1:0]          out_idx_reg;
    logic                      out_valid_reg;

    logic [BYTE_W-1:0] put_byte;
    logic [5:0]        len_base;
    logic [WORD_W-1:0] w0, w2, w8, w13, w_new, f, t;

    // byte source
    assign len_base = {~cmd.len_idx, 3'b000};
    always_comb begin
        case (cmd.byte_sel)
            SEL_MSG:  put_byte = in_byte;
            SEL_PAD:  put_byte = PAD_BYTE;
            SEL_ZERO: put_byte = '0;
            SEL_LEN:  put_byte = len_reg[len_base +: BYTE_W];
            default:  put_byte = '0;
        endcase
    end

    // message schedule taps on the block window
    assign w0    = blk_reg[BLOCK_W-1 -: WORD_W];
    assign w2    = blk_reg[BLOCK_W-1-2*WORD_W -: WORD_W];
    assign w8    = blk_reg[BLOCK_W-1-8*WORD_W -: WORD_W];
    assign w13   = blk_reg[BLOCK_W-1-13*WORD_W -: WORD_W];
    assign w_new = rotl(w13 ^ w8 ^ w2 ^ w0, 1);

    always_comb begin
        if (cmd.round_idx < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
        end else if (cmd.round_idx >= 7'd40 && cmd.round_idx < 7'd60) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
        end else begin
            f = b_reg ^ c_reg ^ d_reg;
        end
    end

    assign t = rotl(a_reg, 5) + f + e_reg + round_k(cmd.round_idx) + w0;

    always_ff @(posedge aclk) begin
        if (cmd.put) begin
            blk_reg <= {blk_reg[BLOCK_W-BYTE_W-1:0], put_byte};
        end else if (cmd.round) begin
            blk_reg <= {blk_reg[BLOCK_W-WORD_W-1:0], w_new};
        end
        if (cmd.load_rounds) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end else if (cmd.round) begin
            a_reg <= t;
            b_reg <= a_reg;
            c_reg <= rotl(b_reg, 30);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.emit) begin
            out_data_reg <= {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
        end else if (out_valid_reg && out_ready) begin
            out_data_reg <= {out_data_reg[(NWORDS-1)*WORD_W-1:0], {WORD_W{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NWORDS; i++) begin
                h_reg[i] <= IV[i];
            end
            pos_reg       <= '0;
            len_reg       <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.put) begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (cmd.emit) begin
                for (int i = 0; i < NWORDS; i++) begin
                    h_reg[i] <= IV[i];
                end
                len_reg       <= '0;
                out_idx_reg   <= '0;
                out_valid_reg <= 1'b1;
            end else begin
                if (cmd.add_h) begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                end
                if (cmd.add_len) begin
                    len_reg <= len_reg + BITS_PER_BYTE;
                end
                if (out_valid_reg && out_ready) begin
                    out_idx_reg <= out_idx_reg + 1'b1;
                    if (out_idx_reg == LAST_WORD) begin
                        out_valid_reg <= 1'b0;
                    end
                end
            end
        end
    end

    assign status.pos_full   = (pos_reg == POS_FULL);
    assign status.pos_at_len = (pos_reg == POS_LEN);
    assign status.out_busy   = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_word  = out_data_reg[NWORDS*WORD_W-1 -: WORD_W];
    assign out_idx   = out_idx_reg;
    assign out_last  = (out_idx_reg == LAST_WORD);

`ifndef NO_ASSERTIONS
    // the output stage drains only after the fifth word
    a_drain_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(out_valid_reg) |-> ($past(out_idx_reg) == LAST_WORD && $past(out_ready)))
        else $error("digest output ended early");

    // a new digest is never loaded over one still being sent
    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !out_valid_reg)
        else $error("digest overwritten before transfer");

    // after a digest the next message starts on a block boundary
    a_emit_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (pos_reg == '0))
        else $error("block position not cleared at digest");
`endif

endmodule
